/* hdl/lpht_pkg.sv */
package lpht_pkg;

    // One request as it arrives on the command port
    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] key_address;
        logic [63:0] site_value;
        logic [63:0] size_value;
    } t_item;

    // One result as it leaves on the result port
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] site_out;
        logic [63:0] size_out;
    } t_result;

    // Operation codes
    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_FORGET = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    // Fibonacci hash constants
    localparam logic [63:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;
    localparam int unsigned MIX_SHIFT   = 21;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL0,
        F_MUL1,
        F_MUL2,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CHECK
    } t_back_state;

endpackage

/* hdl/lpht_front.sv */
module lpht_front
    import lpht_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_item                 i_item,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_item                 o_item,
    output logic [INDEX_BITS-1:0] o_home
);

    t_front_state r_state, n_state;
    t_item        r_item;
    logic [63:0]  r_mix;
    logic [63:0]  r_acc;
    logic [31:0]  w_opa;
    logic [31:0]  w_opb;
    logic [63:0]  w_prod;

    // Shared 32x32 multiplier, one partial product per cycle
    always_comb begin
        case (r_state)
            F_MUL0: begin
                w_opa = r_mix[31:0];
                w_opb = GOLDEN_MULT[31:0];
            end
            F_MUL1: begin
                w_opa = r_mix[63:32];
                w_opb = GOLDEN_MULT[31:0];
            end
            default: begin
                w_opa = r_mix[31:0];
                w_opb = GOLDEN_MULT[63:32];
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) n_state = F_MUL0;
            end
            F_MUL0: n_state = F_MUL1;
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Payload: latch on transfer, accumulate the low 64 bits of the product
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    r_item <= i_item;
                    r_mix  <= i_item.key_address ^ (i_item.key_address >> MIX_SHIFT);
                end
            end
            F_MUL0: r_acc <= w_prod;
            F_MUL1, F_MUL2: r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            default: ;
        endcase
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_item = r_item;
    assign o_home = r_acc[63 -: INDEX_BITS];

endmodule

/* hdl/lpht_queue.sv */
module lpht_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    // Two-entry ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

/* hdl/lpht_back.sv */
module lpht_back
    import lpht_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_item                 i_q_item,
    input  logic [INDEX_BITS-1:0] i_q_home,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_done,
    output t_result               o_result
);

    localparam int SLOTS = 1 << INDEX_BITS;

    // Table stores
    logic [63:0] r_key_mem  [SLOTS];
    logic [63:0] r_site_mem [SLOTS];
    logic [63:0] r_size_mem [SLOTS];
    logic [63:0] r_key_rd;
    logic [63:0] r_site_rd;
    logic [63:0] r_size_rd;

    t_back_state           r_state, n_state;
    t_item                 r_job, n_job;
    logic [INDEX_BITS-1:0] r_slot, n_slot;
    logic [INDEX_BITS-1:0] r_cnt, n_cnt;
    logic [INDEX_BITS-1:0] r_clr, n_clr;
    logic                  r_done, n_done;
    t_result               r_result, n_result;

    logic                  w_key_we;
    logic [INDEX_BITS-1:0] w_key_waddr;
    logic [63:0]           w_key_wdata;
    logic                  w_data_we;
    logic                  w_empty;
    logic                  w_hit;
    logic                  w_last;

    function automatic t_result mk_result(logic [1:0] status, logic found,
                                          logic [63:0] site, logic [63:0] size);
        t_result r;
        r.status   = status;
        r.found    = found;
        r.site_out = site;
        r.size_out = size;
        return r;
    endfunction

    // Memory ports: one write, one registered read at the probe slot
    always_ff @(posedge i_clk) begin
        if (w_key_we) r_key_mem[w_key_waddr] <= w_key_wdata;
        if (w_data_we) begin
            r_site_mem[r_slot] <= r_job.site_value;
            r_size_mem[r_slot] <= r_job.size_value;
        end
        r_key_rd  <= r_key_mem[r_slot];
        r_site_rd <= r_site_mem[r_slot];
        r_size_rd <= r_size_mem[r_slot];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign w_empty = (r_key_rd == 64'd0);
    assign w_hit   = (r_key_rd == r_job.key_address);
    assign w_last  = (r_cnt == {INDEX_BITS{1'b1}});

    // Probe sequencer
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        n_done      = 1'b0;
        n_result    = r_result;
        o_pop       = 1'b0;
        w_key_we    = 1'b0;
        w_key_waddr = r_slot;
        w_key_wdata = r_job.key_address;
        w_data_we   = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                w_key_we    = 1'b1;
                w_key_waddr = r_clr;
                w_key_wdata = 64'd0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == {INDEX_BITS{1'b1}}) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_q_item;
                    n_slot = i_q_home;
                    n_cnt  = '0;
                    if ((i_q_item.mode == MODE_RECORD || i_q_item.mode == MODE_FORGET)
                        && i_q_item.key_address == 64'd0) begin
                        n_done   = 1'b1;
                        n_result = mk_result(ST_NULL, 1'b0, 64'd0, 64'd0);
                    end else if (i_q_item.mode == MODE_RECORD
                                 || i_q_item.mode == MODE_FORGET
                                 || i_q_item.mode == MODE_LOOKUP) begin
                        n_state = B_READ;
                    end else begin
                        n_done   = 1'b1;
                        n_result = mk_result(ST_MISS, 1'b0, 64'd0, 64'd0);
                    end
                end
            end
            B_READ: n_state = B_CHECK;
            B_CHECK: begin
                n_state = B_IDLE;
                n_done  = 1'b1;
                unique case (r_job.mode)
                    MODE_RECORD: begin
                        if (w_empty || w_hit) begin
                            w_key_we  = 1'b1;
                            w_data_we = 1'b1;
                            n_result  = mk_result(ST_OK, 1'b0, 64'd0, 64'd0);
                        end else if (w_last) begin
                            n_result = mk_result(ST_FULL, 1'b0, 64'd0, 64'd0);
                        end else begin
                            n_done = 1'b0;
                        end
                    end
                    MODE_FORGET: begin
                        if (w_empty) begin
                            n_result = mk_result(ST_MISS, 1'b0, 64'd0, 64'd0);
                        end else if (w_hit) begin
                            w_key_we    = 1'b1;
                            w_key_wdata = 64'd0;
                            n_result    = mk_result(ST_OK, 1'b0, 64'd0, 64'd0);
                        end else if (w_last) begin
                            n_result = mk_result(ST_MISS, 1'b0, 64'd0, 64'd0);
                        end else begin
                            n_done = 1'b0;
                        end
                    end
                    default: begin
                        if (w_empty) begin
                            n_result = mk_result(ST_MISS, 1'b0, 64'd0, 64'd0);
                        end else if (w_hit) begin
                            n_result = mk_result(ST_OK, 1'b1, r_site_rd, r_size_rd);
                        end else if (w_last) begin
                            n_result = mk_result(ST_MISS, 1'b0, 64'd0, 64'd0);
                        end else begin
                            n_done = 1'b0;
                        end
                    end
                endcase
                // keep walking upward, wrapping
                if (!n_done) begin
                    n_state = B_READ;
                    n_slot  = r_slot + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_done     = r_done;
    assign o_result   = r_result;

`ifndef SYNTHESIS
    // no result while the key store is being cleared
    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !r_done)
        else $error("result issued during clearing pass");

    // a hit is only ever reported with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_result.found) |-> (r_result.status == ST_OK))
        else $error("found set without ok status");

    // table writes outside the clearing pass come only from record or forget
    a_write_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_key_we && r_state != B_CLEAR)
            |-> (r_job.mode == MODE_RECORD || r_job.mode == MODE_FORGET))
        else $error("key store written by a lookup");

    // a table probe is never started straight from the clearing pass
    a_clear_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == B_CLEAR) && r_state != B_CLEAR |-> r_state == B_IDLE)
        else $error("clearing pass left into a probe state");
`endif

endmodule

/* hdl/linear_probe_hash_side_table.sv */
// Object metadata side table: open addressing, linear probing, Fibonacci hash.
//
// Command channel: drive i_item and raise start; the transfer happens at the
// clock edge where start is high and busy is low. Modes are record, forget and
// lookup. Result channel: o_done is high for exactly one cycle with o_result
// valid; the receiver cannot hold it off, so it must take every result.
//
// A front stage latches the command and forms the home slot with one shared
// 32x32 multiplier over the F_MUL0, F_MUL1 and F_MUL2 states, then hands it to
// a two-entry queue. A back stage walks the probe chain; each probed slot takes
// a registered memory read, then a compare and write. The front stage can take
// a new command once it has pushed the last one into the queue, while the back
// stage may still be probing for an earlier one. Null-key record or forget, and
// an unused mode, answer without probing.
//
// After reset the key store is cleared, one slot a cycle, across all 2^INDEX_BITS
// slots; busy stays high during that pass and no command is taken.
module linear_probe_hash_side_table
    import lpht_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    localparam int QW = INDEX_BITS + $bits(t_item);

    logic                  w_front_busy;
    logic                  w_clearing;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_full;
    logic                  w_empty;
    t_item                 w_front_item;
    logic [INDEX_BITS-1:0] w_front_home;
    logic [QW-1:0]         w_q_out;
    t_item                 w_q_item;
    logic [INDEX_BITS-1:0] w_q_home;

    assign busy = w_front_busy | w_clearing;

    lpht_front #(
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start & ~busy),
        .o_busy   (w_front_busy),
        .i_item   (i_item),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_front_item),
        .o_home   (w_front_home)
    );

    lpht_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_home, w_front_item}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_out)
    );

    assign w_q_item = w_q_out[$bits(t_item)-1:0];
    assign w_q_home = w_q_out[QW-1 -: INDEX_BITS];

    lpht_back #(
        .INDEX_BITS(INDEX_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_empty),
        .i_q_item   (w_q_item),
        .i_q_home   (w_q_home),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
